// ----- src/ttfb_pkg.sv -----
// Package of the text framebuffer renderer: screen defaults, glyph ROM,
// request codes, sequencer states and the structs passed between modules.
// Depends on nothing.
`default_nettype none

package ttfb_pkg;

   localparam int SCREEN_WIDTH_DEF  = 84;
   localparam int SCREEN_HEIGHT_DEF = 48;
   localparam int GLYPH_W           = 5;
   localparam int GLYPH_H           = 7;
   localparam int ADV_X             = 5 + 1;
   localparam int ADV_Y             = 7 + 1;
   localparam int FIRST_CODE        = 32;
   localparam int LAST_CODE         = 127;
   localparam int GLYPH_STEPS       = 2 * GLYPH_W;
   localparam int GLYPH_COUNT       = LAST_CODE - FIRST_CODE + 1;

   localparam logic [1:0] REQ_DRAW  = 2'd0;
   localparam logic [1:0] REQ_CLEAR = 2'd1;
   localparam logic [1:0] REQ_READ  = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_RWAIT,
      ST_DRAW,
      ST_DRAIN,
      ST_DONE
   } ttfb_state_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] char_code;
      logic       first_of_string;
      logic [6:0] start_col;
      logic [5:0] start_row;
      logic [8:0] byte_index;
   } ttfb_request_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] read_data;
      logic [6:0] cursor_col;
      logic [5:0] cursor_row;
   } ttfb_result_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } ttfb_mem_ctl_type;

   function automatic int fb_pages(input int height);
      return (height + 7) / 8;
   endfunction

   function automatic int fb_bytes(input int width, input int height);
      return width * fb_pages(height);
   endfunction

   function automatic int max_int(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

   // Column 0 of each glyph in the top byte.
   localparam logic [39:0] GLYPH_ROM [GLYPH_COUNT] = '{
      40'h0000000000, 40'h00005f0000, 40'h0007000700, 40'h147f147f14,
      40'h242a7f2a12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
      40'h001c224100, 40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
      40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
      40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
      40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503,
      40'h3649494936, 40'h064949291e, 40'h0036360000, 40'h0056360000,
      40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
      40'h324979413e, 40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
      40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
      40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241,
      40'h7f40404040, 40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
      40'h7f09090906, 40'h3e4151215e, 40'h7f09192946, 40'h4649494931,
      40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f,
      40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
      40'h0204081020, 40'h0041417f00, 40'h0402010204, 40'h4040404040,
      40'h0001020400, 40'h2054545478, 40'h7f48444438, 40'h3844444420,
      40'h384444487f, 40'h3854545418, 40'h087e090102, 40'h0c5252523e,
      40'h7f08040478, 40'h00447d4000, 40'h2040443d00, 40'h7f10284400,
      40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
      40'h7c14141408, 40'h081414187c, 40'h7c08040408, 40'h4854545420,
      40'h043f444020, 40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c,
      40'h4428102844, 40'h0c5050503c, 40'h4464544c44, 40'h0008364100,
      40'h00007f0000, 40'h0041360800, 40'h1008081008, 40'h0000000000
   };

   function automatic logic [GLYPH_H-1:0] glyph_column(input logic [7:0] code,
                                                       input logic [2:0] col);
      logic [6:0]  idx;
      logic [39:0] entry;
      logic [7:0]  bits;
      if (code < 8'(FIRST_CODE) || code > 8'(LAST_CODE)) begin
         return '0;
      end
      idx   = 7'(code - 8'(FIRST_CODE));
      entry = GLYPH_ROM[idx];
      unique case (col)
         3'd0:    bits = entry[39:32];
         3'd1:    bits = entry[31:24];
         3'd2:    bits = entry[23:16];
         3'd3:    bits = entry[15:8];
         3'd4:    bits = entry[7:0];
         default: bits = '0;
      endcase
      return bits[GLYPH_H-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- src/ttfb_mem.sv -----
// Framebuffer store: one write port and one read port, read data registered.
// Depends on ttfb_pkg for the port control struct.
`default_nettype none

module ttfb_mem #(
   parameter int DEPTH = ttfb_pkg::fb_bytes(ttfb_pkg::SCREEN_WIDTH_DEF,
                                           ttfb_pkg::SCREEN_HEIGHT_DEF),
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire                         clock,
   input  ttfb_pkg::ttfb_mem_ctl_type  ctl,
   input  wire  [AW-1:0]               waddr,
   input  wire  [7:0]                  wdata,
   input  wire  [AW-1:0]               raddr,
   output logic [7:0]                  rdata
);
   import ttfb_pkg::*;

   logic [7:0] store [DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         store[waddr] <= wdata;
      end
      if (ctl.rd_en) begin
         rdata_ff <= store[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- src/ttfb_seq.sv -----
// Request sequencer: cursor, clearing sweep, byte reads and the glyph
// read-modify-write pipeline against the framebuffer store.
// Depends on ttfb_pkg for the glyph ROM, codes, states and structs.
`default_nettype none

module ttfb_seq #(
   parameter int SCREEN_WIDTH  = ttfb_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = ttfb_pkg::SCREEN_HEIGHT_DEF,
   parameter int AW = $clog2(ttfb_pkg::fb_bytes(SCREEN_WIDTH, SCREEN_HEIGHT))
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_ready,
   input  ttfb_pkg::ttfb_request_type  req,
   output ttfb_pkg::ttfb_result_type   res,
   input  wire                         res_free,
   output ttfb_pkg::ttfb_mem_ctl_type  mem_ctl,
   output logic [AW-1:0]               mem_waddr,
   output logic [7:0]                  mem_wdata,
   output logic [AW-1:0]               mem_raddr,
   input  wire  [7:0]                  mem_rdata
);
   import ttfb_pkg::*;

   localparam int FB_BYTES = fb_bytes(SCREEN_WIDTH, SCREEN_HEIGHT);
   localparam int CCW      = $clog2(max_int(SCREEN_WIDTH, 128) + ADV_X);
   localparam int CRW      = $clog2(max_int(SCREEN_HEIGHT, 64) + ADV_Y);
   localparam int PW       = CRW - 2;
   localparam int SW       = $clog2(GLYPH_STEPS);
   localparam int SPAN     = 8 + GLYPH_H;
   localparam logic [SPAN-1:0] BOX_BITS = SPAN'((1 << GLYPH_H) - 1);

   ttfb_state_type   state_ff, state_in;
   ttfb_request_type req_ff, req_in;
   logic [SW-1:0]    step_ff, step_in;
   logic [AW-1:0]    clr_ff, clr_in;
   logic             clr_rsp_ff, clr_rsp_in;
   logic [CCW-1:0]   cur_col_ff, cur_col_in;
   logic [CRW-1:0]   cur_row_ff, cur_row_in;
   logic [7:0]       rdat_ff, rdat_in;
   logic             wr_vld_ff, wr_vld_in;
   logic [AW-1:0]    wr_addr_ff, wr_addr_in;
   logic [7:0]       wr_mask_ff, wr_mask_in;
   logic [7:0]       wr_data_ff, wr_data_in;

   logic [2:0]         glyph_x;
   logic               half;
   logic [GLYPH_H-1:0] col_bits;
   logic [SPAN-1:0]    box;
   logic [SPAN-1:0]    dat;
   logic [PW-1:0]      page;
   logic [CCW-1:0]     pix_x;
   logic [7:0]         row_ok;
   logic [7:0]         part_mask;
   logic [7:0]         part_data;
   logic [7:0]         step_mask;
   logic               step_ok;
   logic [AW-1:0]      step_addr;
   logic [CCW-1:0]     adv_col;
   logic [CRW-1:0]     adv_row;

   // Geometry of the current glyph step: one column, one page.
   always_comb begin
      glyph_x  = 3'(step_ff[SW-1:1]);
      half     = step_ff[0];
      col_bits = glyph_column(req_ff.char_code, glyph_x);
      box      = BOX_BITS << cur_row_ff[2:0];
      dat      = SPAN'(col_bits) << cur_row_ff[2:0];
      page     = PW'(cur_row_ff >> 3) + PW'(half);
      pix_x    = cur_col_ff + CCW'(glyph_x);
      for (int k = 0; k < 8; k++) begin
         row_ok[k] = (int'(page) * 8 + k) < SCREEN_HEIGHT;
      end
      part_mask = half ? 8'(box[SPAN-1:8]) : box[7:0];
      part_data = half ? 8'(dat[SPAN-1:8]) : dat[7:0];
      step_mask = part_mask & row_ok;
      step_ok   = (int'(pix_x) < SCREEN_WIDTH) && (step_mask != 8'd0);
      step_addr = AW'(int'(page) * SCREEN_WIDTH + int'(pix_x));
   end

   always_comb begin
      adv_col = cur_col_ff + CCW'(ADV_X);
      adv_row = cur_row_ff;
      if (int'(adv_col) >= SCREEN_WIDTH) begin
         adv_col = '0;
         adv_row = cur_row_ff + CRW'(ADV_Y);
      end
      if (int'(adv_row) >= SCREEN_HEIGHT) begin
         adv_col = '0;
         adv_row = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_ff     <= '0;
         clr_rsp_ff <= 1'b0;
         cur_col_ff <= '0;
         cur_row_ff <= '0;
         wr_vld_ff  <= 1'b0;
         step_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         clr_rsp_ff <= clr_rsp_in;
         cur_col_ff <= cur_col_in;
         cur_row_ff <= cur_row_in;
         wr_vld_ff  <= wr_vld_in;
         step_ff    <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      rdat_ff    <= rdat_in;
      wr_addr_ff <= wr_addr_in;
      wr_mask_ff <= wr_mask_in;
      wr_data_ff <= wr_data_in;
   end

   always_comb begin
      state_in   = state_ff;
      req_in     = req_ff;
      step_in    = step_ff;
      clr_in     = clr_ff;
      clr_rsp_in = clr_rsp_ff;
      cur_col_in = cur_col_ff;
      cur_row_in = cur_row_ff;
      rdat_in    = rdat_ff;
      wr_vld_in  = 1'b0;
      wr_addr_in = step_addr;
      wr_mask_in = step_mask;
      wr_data_in = part_data;
      req_ready  = 1'b0;
      mem_ctl    = '0;
      mem_waddr  = wr_addr_ff;
      mem_wdata  = (mem_rdata & ~wr_mask_ff) | (wr_data_ff & wr_mask_ff);
      mem_raddr  = step_addr;
      res.valid      = 1'b0;
      res.read_data  = rdat_ff;
      res.cursor_col = 7'(cur_col_ff);
      res.cursor_row = 6'(cur_row_ff);

      // write back the byte read in the previous draw step
      if (wr_vld_ff) begin
         mem_ctl.wr_en = 1'b1;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_ctl.wr_en = 1'b1;
            mem_waddr     = clr_ff;
            mem_wdata     = '0;
            clr_in        = clr_ff + AW'(1);
            if (clr_ff == AW'(FB_BYTES - 1)) begin
               state_in = clr_rsp_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in  = req;
               rdat_in = '0;
               unique case (req.req_type)
                  REQ_DRAW: begin
                     if (req.first_of_string) begin
                        cur_col_in = CCW'(req.start_col);
                        cur_row_in = CRW'(req.start_row);
                     end
                     step_in  = '0;
                     state_in = ST_DRAW;
                  end
                  REQ_CLEAR: begin
                     cur_col_in = '0;
                     cur_row_in = '0;
                     clr_in     = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = ST_CLEAR;
                  end
                  REQ_READ: begin
                     state_in = ST_READ;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_READ: begin
            mem_ctl.rd_en = 32'(req_ff.byte_index) < 32'(FB_BYTES);
            mem_raddr     = AW'(req_ff.byte_index);
            state_in      = ST_RWAIT;
         end
         ST_RWAIT: begin
            rdat_in  = (32'(req_ff.byte_index) < 32'(FB_BYTES)) ? mem_rdata : 8'd0;
            state_in = ST_DONE;
         end
         ST_DRAW: begin
            mem_ctl.rd_en = step_ok;
            wr_vld_in     = step_ok;
            step_in       = step_ff + SW'(1);
            if (step_ff == SW'(GLYPH_STEPS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            cur_col_in = adv_col;
            cur_row_in = adv_row;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            res.valid  = 1'b1;
            clr_rsp_in = 1'b0;
            if (res_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      mem_ctl.wr_en |-> (mem_waddr <= AW'(FB_BYTES - 1)))
      else $error("framebuffer write beyond the store");

   a_no_rmw_overlap: assert property (@(posedge clock) disable iff (reset)
      (wr_vld_ff && mem_ctl.rd_en) |-> (mem_raddr != wr_addr_ff))
      else $error("glyph read hits the byte still being written");

   a_cursor_on_screen: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && req_ff.req_type == REQ_DRAW) |->
      ((int'(cur_col_ff) < SCREEN_WIDTH) && (int'(cur_row_ff) < SCREEN_HEIGHT)))
      else $error("cursor off screen after a draw");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !mem_ctl.wr_en)
      else $error("framebuffer written while idle");

endmodule

`default_nettype wire

// ----- src/text_to_framebuffer_renderer.sv -----
// Usage: one request channel (req_valid/req_ready) carries draw, clear and
// read items; one result channel (rsp_valid/rsp_ready) returns one item per
// request with the read byte and the cursor after the request.
// A draw walks the 5 glyph columns over two pages, one byte read per cycle
// through the store's read port with the modified byte written back on the
// next cycle; the next item can be accepted from the cycle after the result
// is handed to the output register. Clear writes one byte per cycle through
// the write port, and an unused request type goes straight to its result.
// At reset the store is swept to zero with req_ready low; the cursor goes
// to 0,0 at once.
// The result sits in an output register; when the receiver stalls, the
// next request is still taken and worked on, and its result waits in the
// sequencer until the output register frees.
// Depends on ttfb_pkg, ttfb_seq and ttfb_mem.
`default_nettype none

module text_to_framebuffer_renderer #(
   parameter int SCREEN_WIDTH  = ttfb_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = ttfb_pkg::SCREEN_HEIGHT_DEF
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_ready,
   input  wire  [1:0] req_type,
   input  wire  [7:0] req_char_code,
   input  wire        req_first_of_string,
   input  wire  [6:0] req_start_col,
   input  wire  [5:0] req_start_row,
   input  wire  [8:0] req_byte_index,
   output logic       rsp_valid,
   input  wire        rsp_ready,
   output logic [7:0] rsp_read_data,
   output logic [6:0] rsp_cursor_col,
   output logic [5:0] rsp_cursor_row
);
   import ttfb_pkg::*;

   localparam int FB_BYTES = fb_bytes(SCREEN_WIDTH, SCREEN_HEIGHT);
   localparam int AW       = $clog2(FB_BYTES);

   ttfb_request_type req;
   ttfb_result_type  res;
   ttfb_mem_ctl_type mem_ctl;
   logic [AW-1:0]    mem_waddr;
   logic [7:0]       mem_wdata;
   logic [AW-1:0]    mem_raddr;
   logic [7:0]       mem_rdata;
   logic             res_free;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff;
   logic [6:0] rsp_col_ff;
   logic [5:0] rsp_row_ff;

   always_comb begin
      req.req_type        = req_type;
      req.char_code       = req_char_code;
      req.first_of_string = req_first_of_string;
      req.start_col       = req_start_col;
      req.start_row       = req_start_row;
      req.byte_index      = req_byte_index;
   end

   ttfb_seq #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .AW            (AW)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .res       (res),
      .res_free  (res_free),
      .mem_ctl   (mem_ctl),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   ttfb_mem #(
      .DEPTH (FB_BYTES),
      .AW    (AW)
   ) u_mem (
      .clock (clock),
      .ctl   (mem_ctl),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign res_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res.valid && res_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res.valid && res_free) begin
         rsp_data_ff <= res.read_data;
         rsp_col_ff  <= res.cursor_col;
         rsp_row_ff  <= res.cursor_row;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_data  = rsp_data_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cursor_row = rsp_row_ff;

endmodule

`default_nettype wire
